// ===== hw/rtl/sphere_contact_generator_top_assert.svh =====
// Assertion macros for the sphere contact generator.
`ifndef SPHERE_CONTACT_GENERATOR_TOP_ASSERT_SVH
`define SPHERE_CONTACT_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define SCG_ASSERT_IMP(lbl, pre, post) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (pre) |-> (post)) else $error("scg check failed");
`define SCG_ASSERT_NXT(lbl, pre, post) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (pre) |=> (post)) else $error("scg check failed");
`else
`define SCG_ASSERT_IMP(lbl, pre, post)
`define SCG_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ===== hw/rtl/scg_pkg.sv =====
// Shared types and constants of the sphere contact generator.
`default_nettype none
package scg_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam logic [15:0] BUDGET_RESET = 16'd100;
    localparam int IN_DATA_W  = 272;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 200;
    localparam int SQRT_STEPS = 34;

    typedef enum logic [1:0] {
        KIND_SPHERE = 2'd0,
        KIND_PLANE  = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MUL_SQ,
        OP_ACC_SQ,
        OP_MUL_DOT,
        OP_ACC_DOT,
        OP_SQRT,
        OP_DIST,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_MUL_PLO,
        OP_ACC_PLO,
        OP_MUL_PHI,
        OP_ACC_PHI,
        OP_PROJ,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] axis;
        logic       hit;
        logic       empty;
    } dp_cmd_t;

    typedef struct packed {
        logic hit_ss;
        logic hit_hs;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sphere_contact_generator_top.sv =====
// Sphere contact generator: top level with register port, controller and datapath.
//
// Input stream (s_*): one word per pair test or budget clear. s_tuser holds the
// kind, s_tdata the two shapes and the pair tag. Output stream (m_*): exactly
// one word per input word, in order; m_tuser is the hit flag.
// Each item runs a controller sequence on the shared 33x33 multiplier, the
// one-bit-per-cycle square root and the restoring divider; with the default
// FRAC_BITS of 16 the coordinates are Q16.16. A clear, an unused kind or a
// spent budget goes straight to the result. One item is worked at a time;
// s_tready is high while the block waits for the next word.
// The result sits in an output register, so a new word is accepted while the
// previous result waits; a stalled receiver holds the block only when the
// next result is ready and the register is still full.
// Reset empties the output register and loads 100 into both the contact
// budget register and the remaining count.
`default_nettype none
module sphere_contact_generator_top #(
    parameter int FRAC_BITS = scg_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // first_x, first_y, first_z, first_radius, second_x, second_y, second_z,
    // second_scalar, pair_tag, zero pad
    input  wire logic [scg_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind
    input  wire logic [scg_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // point_x, point_y, point_z, normal_x, normal_y, normal_z, penetration,
    // tag_out, budget_empty, zero pad
    output logic [scg_pkg::OUT_DATA_W-1:0]       m_tdata,
    // hit
    output logic                                 m_tuser,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [2:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import scg_pkg::*;

    logic [15:0] budget_reg;
    logic        cfg_wr;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {16'd0, budget_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            budget_reg <= BUDGET_RESET;
        else if (cfg_wr)
            budget_reg <= pwdata[15:0];
    end

    scg_ctrl #(
        .FRAC (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind_in  (kind_t'(s_tuser)),
        .budget   (budget_reg),
        .status   (status),
        .cmd      (cmd)
    );

    scg_datapath #(
        .FRAC (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`include "sphere_contact_generator_top_assert.svh"

    `SCG_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata[181:0] == 182'd0)
    `SCG_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready)
    `SCG_ASSERT_NXT(a_cfg_write, cfg_wr, budget_reg == $past(pwdata[15:0]))

endmodule
`default_nettype wire

// ===== hw/rtl/scg_datapath.sv =====
// Datapath: operand capture, shared multiplier, sqrt, divider and output register.
`default_nettype none
module scg_datapath #(
    parameter int FRAC = scg_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [scg_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire scg_pkg::dp_cmd_t               cmd,
    output scg_pkg::dp_status_t                 status,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic [scg_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser
);
    import scg_pkg::*;

    localparam int QW    = FRAC + 2;
    localparam int NUMW  = 34 + FRAC;
    localparam int DVW   = 33 + QW;
    localparam int DCW   = 33 + FRAC;
    localparam int DHW   = DCW - 32;
    localparam int PW    = 64 + FRAC;
    localparam int DISTW = 69 - FRAC;
    localparam int XW    = (DISTW > DCW) ? DISTW : DCW;
    localparam logic [DCW-1:0] DCLAMP = DCW'(1) << (32 + FRAC);
    localparam logic [63:0] QCLAMP = 64'd1 << 33;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [31:0] v);
        logic signed [17:0] r;
        if (v > 32'sd131071)
            r = 18'sd131071;
        else if (v < -32'sd131072)
            r = -18'sd131072;
        else
            r = v[17:0];
        return r;
    endfunction

    // captured item
    logic signed [31:0] a_reg [3];
    logic signed [31:0] b_reg [3];
    logic [30:0]        rad_reg;
    logic signed [31:0] sc_reg;
    logic [15:0]        tag_reg;
    kind_t              kind_reg;

    logic [65:0]             prod_reg;
    logic signed [67:0]      acc_reg;
    logic [33:0]             root_reg;
    logic [35:0]             rem_reg;
    logic signed [DISTW-1:0] dist_reg;
    logic [NUMW-1:0]         drem_reg;
    logic [DVW-1:0]          dsh_reg;
    logic [QW-1:0]           q_reg;
    logic [PW-1:0]           pacc_reg;
    logic signed [31:0]      pt_reg [3];
    logic signed [17:0]      nm_reg [3];
    logic                    m_valid_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    out_hit_reg;

    logic signed [32:0] d [3];
    logic [32:0]        dmag [3];
    logic [31:0]        amag [3];
    logic [31:0]        bmag [3];
    logic signed [31:0] mid [3];
    logic [DISTW-1:0]   dist_mag;
    logic [DCW-1:0]     dcl;
    logic [32:0]        mul_a;
    logic [32:0]        mul_b;
    logic signed [32:0] rsum;
    logic [36:0]        rem_sh;
    logic [36:0]        trial;
    logic               dv_ge;
    logic [63:0]        pq;
    logic [33:0]        pqc;
    logic [34:0]        pmag;
    logic               pneg;
    logic signed [35:0] pm;
    logic signed [35:0] pt36;
    logic [31:0]        qx;
    logic signed [17:0] nm_div;
    logic signed [31:0] pen;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i]    = {b_reg[i][31], b_reg[i]} - {a_reg[i][31], a_reg[i]};
            dmag[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
            amag[i] = a_reg[i][31] ? 32'(-a_reg[i]) : 32'(a_reg[i]);
            bmag[i] = b_reg[i][31] ? 32'(-b_reg[i]) : 32'(b_reg[i]);
            mid[i]  = 32'(({a_reg[i][31], a_reg[i]} + {b_reg[i][31], b_reg[i]}) >>> 1);
        end
    end

    // |distance| clamped: anything past the clamp saturates the point anyway
    assign dist_mag = dist_reg[DISTW-1] ? DISTW'(-dist_reg) : DISTW'(dist_reg);
    assign dcl = (XW'(dist_mag) > XW'(DCLAMP)) ? DCLAMP : DCW'(dist_mag);

    always_comb
    begin
        unique case (cmd.op)
            OP_MUL_SQ:
            begin
                mul_a = dmag[cmd.axis];
                mul_b = dmag[cmd.axis];
            end
            OP_MUL_DOT:
            begin
                mul_a = {1'b0, amag[cmd.axis]};
                mul_b = {1'b0, bmag[cmd.axis]};
            end
            OP_MUL_PLO:
            begin
                mul_a = {1'b0, bmag[cmd.axis]};
                mul_b = {1'b0, dcl[31:0]};
            end
            OP_MUL_PHI:
            begin
                mul_a = {1'b0, bmag[cmd.axis]};
                mul_b = {{(33 - DHW){1'b0}}, dcl[DCW-1:32]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rsum   = $signed({2'b00, rad_reg}) + $signed({sc_reg[31], sc_reg});
    assign rem_sh = {rem_reg[34:0], acc_reg[67:66]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign dv_ge  = DVW'(drem_reg) >= dsh_reg;

    // projection: floor(b * distance / 2^FRAC)
    assign pq   = pacc_reg[PW-1:FRAC];
    assign pqc  = (pq > QCLAMP) ? QCLAMP[33:0] : pq[33:0];
    assign pneg = b_reg[cmd.axis][31] ^ dist_reg[DISTW-1];
    assign pmag = {1'b0, pqc} + 35'((pneg && (|pacc_reg[FRAC-1:0])) ? 1 : 0);
    assign pm   = pneg ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
    assign pt36 = $signed({{4{a_reg[cmd.axis][31]}}, a_reg[cmd.axis]}) - pm;

    assign qx = 32'(q_reg);
    always_comb
    begin
        if (!d[cmd.axis][32])
            nm_div = (qx > 32'd131071) ? 18'sd131071 : qx[17:0];
        else
            nm_div = (qx > 32'd131072) ? -18'sd131072 : 18'(-qx);
    end

    always_comb
    begin
        if (kind_reg == KIND_SPHERE)
            pen = sat32(64'($signed({{3{rsum[32]}}, rsum}) - $signed({2'b00, root_reg})));
        else
            pen = sat32(64'($signed({1'b0, DISTW'({1'b0, rad_reg})}) -
                            $signed({dist_reg[DISTW-1], dist_reg})));
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    a_reg[i] <= s_tdata[32*i +: 32];
                    b_reg[i] <= s_tdata[127 + 32*i +: 32];
                end
                rad_reg  <= s_tdata[126:96];
                sc_reg   <= s_tdata[254:223];
                tag_reg  <= s_tdata[270:255];
                acc_reg  <= '0;
                root_reg <= '0;
                rem_reg  <= '0;
            end
            OP_MUL_SQ, OP_MUL_DOT, OP_MUL_PLO, OP_MUL_PHI:
                prod_reg <= mul_a * mul_b;
            OP_ACC_SQ:
                acc_reg <= acc_reg + $signed({2'b00, prod_reg});
            OP_ACC_DOT:
            begin
                if (a_reg[cmd.axis][31] ^ b_reg[cmd.axis][31])
                    acc_reg <= acc_reg - $signed({2'b00, prod_reg});
                else
                    acc_reg <= acc_reg + $signed({2'b00, prod_reg});
            end
            OP_SQRT:
            begin
                acc_reg <= acc_reg <<< 2;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= 36'(rem_sh - trial);
                    root_reg <= {root_reg[32:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[35:0];
                    root_reg <= {root_reg[32:0], 1'b0};
                end
            end
            OP_DIST:
                dist_reg <= DISTW'(acc_reg >>> FRAC) - DISTW'(sc_reg);
            OP_DIV_INIT:
            begin
                drem_reg <= NUMW'({dmag[cmd.axis], {FRAC{1'b0}}}) + NUMW'(root_reg[33:1]);
                dsh_reg  <= DVW'(root_reg) << (QW - 1);
                q_reg    <= '0;
            end
            OP_DIV_STEP:
            begin
                if (dv_ge)
                    drem_reg <= drem_reg - dsh_reg[NUMW-1:0];
                q_reg   <= {q_reg[QW-2:0], dv_ge};
                dsh_reg <= dsh_reg >> 1;
            end
            OP_DIV_END:
            begin
                nm_reg[cmd.axis] <= nm_div;
                pt_reg[cmd.axis] <= mid[cmd.axis];
            end
            OP_ACC_PLO:
                pacc_reg <= PW'(prod_reg);
            OP_ACC_PHI:
                pacc_reg <= pacc_reg + (PW'(prod_reg) << 32);
            OP_PROJ:
            begin
                pt_reg[cmd.axis] <= sat32(64'(pt36));
                nm_reg[cmd.axis] <= sat18(b_reg[cmd.axis]);
            end
            OP_FINISH:
            begin
                out_hit_reg <= cmd.hit;
                if (cmd.hit)
                    out_data_reg <= {1'b0, cmd.empty, tag_reg, pen,
                                     nm_reg[2], nm_reg[1], nm_reg[0],
                                     pt_reg[2], pt_reg[1], pt_reg[0]};
                else
                    out_data_reg <= {1'b0, cmd.empty, tag_reg, 182'd0};
            end
            default:
            begin
            end
        endcase
    end

    // kind kept for the penetration select
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIST)
            kind_reg <= KIND_PLANE;
        else if (cmd.op == OP_MUL_SQ)
            kind_reg <= KIND_SPHERE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.op == OP_FINISH)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    assign status.hit_ss   = (root_reg != '0) &&
                             ($signed({2'b00, root_reg}) <= $signed({{3{rsum[32]}}, rsum}));
    assign status.hit_hs   = dist_reg < $signed(DISTW'({1'b0, rad_reg}));
    assign status.out_busy = m_valid_reg && !m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/scg_ctrl.sv =====
// Controller: sequences one pair test on the datapath and keeps the contact budget.
`default_nettype none
module scg_ctrl #(
    parameter int FRAC = scg_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire scg_pkg::kind_t      kind_in,
    input  wire logic [15:0]         budget,
    input  wire scg_pkg::dp_status_t status,
    output scg_pkg::dp_cmd_t         cmd
);
    import scg_pkg::*;

    localparam int QW = FRAC + 2;
    localparam int CW = $clog2(SQRT_STEPS);

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_MUL    = 16'h0002,
        ST_ACC    = 16'h0004,
        ST_SQRT   = 16'h0008,
        ST_SSCHK  = 16'h0010,
        ST_DINIT  = 16'h0020,
        ST_DSTEP  = 16'h0040,
        ST_DEND   = 16'h0080,
        ST_DIST   = 16'h0100,
        ST_HSCHK  = 16'h0200,
        ST_PLO    = 16'h0400,
        ST_PLOA   = 16'h0800,
        ST_PHI    = 16'h1000,
        ST_PHIA   = 16'h2000,
        ST_PROJ   = 16'h4000,
        ST_FINISH = 16'h8000
    } state_t;

    state_t         state_reg, state_next;
    logic [1:0]     ax_reg, ax_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    kind_t          kind_reg, kind_next;
    logic           hit_reg, hit_next;
    logic [15:0]    remain_reg, remain_next;
    logic [15:0]    remain_after;
    logic           sphere;

    assign sphere   = (kind_reg == KIND_SPHERE);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        remain_after = (kind_reg == KIND_CLEAR) ? budget : remain_reg;
        if (hit_reg)
            remain_after = remain_after - 16'd1;
    end

    always_comb
    begin
        state_next  = state_reg;
        ax_next     = ax_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        hit_next    = hit_reg;
        remain_next = remain_reg;
        cmd.op      = OP_IDLE;
        cmd.axis    = ax_reg;
        cmd.hit     = hit_reg;
        cmd.empty   = (remain_after == 16'd0);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op    = OP_LOAD;
                    kind_next = kind_in;
                    hit_next  = 1'b0;
                    ax_next   = 2'd0;
                    if ((kind_in == KIND_SPHERE || kind_in == KIND_PLANE) &&
                        remain_reg != 16'd0)
                        state_next = ST_MUL;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_MUL:
            begin
                cmd.op     = sphere ? OP_MUL_SQ : OP_MUL_DOT;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op = sphere ? OP_ACC_SQ : OP_ACC_DOT;
                if (ax_reg == 2'd2)
                begin
                    ax_next    = 2'd0;
                    cnt_next   = '0;
                    state_next = sphere ? ST_SQRT : ST_DIST;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SQRT_STEPS - 1))
                    state_next = ST_SSCHK;
            end
            ST_SSCHK:
            begin
                hit_next   = status.hit_ss;
                state_next = status.hit_ss ? ST_DINIT : ST_FINISH;
            end
            ST_DINIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                    state_next = ST_DEND;
            end
            ST_DEND:
            begin
                cmd.op     = OP_DIV_END;
                ax_next    = ax_reg + 2'd1;
                state_next = (ax_reg == 2'd2) ? ST_FINISH : ST_DINIT;
            end
            ST_DIST:
            begin
                cmd.op     = OP_DIST;
                state_next = ST_HSCHK;
            end
            ST_HSCHK:
            begin
                hit_next   = status.hit_hs;
                state_next = status.hit_hs ? ST_PLO : ST_FINISH;
            end
            ST_PLO:
            begin
                cmd.op     = OP_MUL_PLO;
                state_next = ST_PLOA;
            end
            ST_PLOA:
            begin
                cmd.op     = OP_ACC_PLO;
                state_next = ST_PHI;
            end
            ST_PHI:
            begin
                cmd.op     = OP_MUL_PHI;
                state_next = ST_PHIA;
            end
            ST_PHIA:
            begin
                cmd.op     = OP_ACC_PHI;
                state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                cmd.op     = OP_PROJ;
                ax_next    = ax_reg + 2'd1;
                state_next = (ax_reg == 2'd2) ? ST_FINISH : ST_PLO;
            end
            ST_FINISH:
            begin
                // hold the result until the output register frees up
                if (!status.out_busy)
                begin
                    cmd.op      = OP_FINISH;
                    remain_next = remain_after;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ax_reg     <= 2'd0;
            cnt_reg    <= '0;
            kind_reg   <= KIND_CLEAR;
            hit_reg    <= 1'b0;
            remain_reg <= BUDGET_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            ax_reg     <= ax_next;
            cnt_reg    <= cnt_next;
            kind_reg   <= kind_next;
            hit_reg    <= hit_next;
            remain_reg <= remain_next;
        end
    end

endmodule
`default_nettype wire
